### rtl/efla_pkg.sv
// Shared constants and codes for the free-list block allocator.
`timescale 1ns / 1ps

package efla_pkg;

  localparam int MAX_BLOCKS = 255;
  localparam int BLK_W      = 8;
  localparam int BYTES_W    = 16;
  localparam int OFFSET_W   = 24;
  localparam int FUNC_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int APB_W      = 32;
  localparam int PADDR_W    = 3;

  localparam logic [BLK_W-1:0] LAST_BLK = BLK_W'(MAX_BLOCKS - 1);
  localparam logic [BLK_W-1:0] MAX_BLK  = BLK_W'(MAX_BLOCKS);
  localparam logic [BLK_W-1:0] EPOCH_TOP = '1;

  localparam logic [FUNC_W-1:0] F_ALLOC  = 3'd0;
  localparam logic [FUNC_W-1:0] F_FREE   = 3'd1;
  localparam logic [FUNC_W-1:0] F_QUERY  = 3'd2;
  localparam logic [FUNC_W-1:0] F_CHECK  = 3'd3;
  localparam logic [FUNC_W-1:0] F_REINIT = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DOUBLE = 2'd3;

  localparam logic REG_NUM_BLOCKS  = 1'b0;
  localparam logic REG_BLOCK_BYTES = 1'b1;

endpackage

### rtl/embedded_free_list_block_allocator_unit.sv
// Free-list block allocator: link memory walker with APB configuration.
// Results: free and unused codes answer straight from idle; allocate reads the head's link first if not empty;
//   query answers at once when settled at the head, else follows links (up to free_total-1);
//   check answers at once when settled without a walk, else tests mark then link per followed link; reinit sweeps.
// Throughput: one word at a time; busy covers the whole walk. The single read port of the
//   link memory (one link per cycle) bounds walk speed.
// Reset: rst_n is synchronous, active low. After reset the block sweeps the link and
//   seen-mark memories with busy high. Once the 255 mark epochs are used up,
//   the next walking check adds a seen-mark clear before its walk.
//   The receiver cannot stall results.
`timescale 1ns / 1ps

module embedded_free_list_block_allocator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // command channel
  input  logic                               start,
  output logic                               busy,
  input  logic [efla_pkg::FUNC_W-1:0]        in_func,
  input  logic [efla_pkg::BLK_W-1:0]         in_block_index,
  // result channel
  output logic                               out_valid,
  output logic [efla_pkg::STATUS_W-1:0]      out_status,
  output logic [efla_pkg::BLK_W-1:0]         out_granted_index,
  output logic [efla_pkg::OFFSET_W-1:0]      out_granted_offset,
  output logic                               out_is_free,
  output logic                               out_corrupt,
  output logic [efla_pkg::BLK_W-1:0]         out_free_count,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [efla_pkg::PADDR_W-1:0]       paddr,
  input  logic [efla_pkg::APB_W-1:0]         pwdata,
  output logic [efla_pkg::APB_W-1:0]         prdata,
  output logic                               pready
);

  // controller states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;  // link read of head in flight
  localparam logic [2:0] S_QUERY = 3'd2;  // one link compared per cycle
  localparam logic [2:0] S_CMARK = 3'd3;  // check: test seen mark, set mark, read link
  localparam logic [2:0] S_CLINK = 3'd4;  // check: range-test link, read its mark
  localparam logic [2:0] S_SWEEP = 3'd5;  // memory sweep, one entry per cycle

  // sweep kinds
  localparam logic [1:0] K_RESET  = 2'd0;
  localparam logic [1:0] K_REINIT = 2'd1;
  localparam logic [1:0] K_SEEN   = 2'd2;  // seen marks only, before a check

  localparam int BW = efla_pkg::BLK_W;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [BW-1:0] cnt_r, cnt_nxt;
  logic [BW-1:0] sweep_n_r, sweep_n_nxt;
  logic [BW-1:0] head_r, head_nxt;
  logic [BW-1:0] total_r, total_nxt;
  logic [BW-1:0] epoch_r, epoch_nxt;
  logic [BW-1:0] idx_r, idx_nxt;
  logic [BW-1:0] rem_r, rem_nxt;
  logic [BW-1:0] blk_r, blk_nxt;
  logic          first_r, first_nxt;

  logic [BW-1:0]                    num_blocks_r;
  logic [efla_pkg::BYTES_W-1:0]     block_bytes_r;

  logic                               out_valid_r, out_valid_nxt;
  logic [efla_pkg::STATUS_W-1:0]      out_status_r, out_status_nxt;
  logic [BW-1:0]                      out_gidx_r, out_gidx_nxt;
  logic [efla_pkg::OFFSET_W-1:0]      out_goff_r, out_goff_nxt;
  logic                               out_isf_r, out_isf_nxt;
  logic                               out_cor_r, out_cor_nxt;
  logic [BW-1:0]                      out_cnt_r, out_cnt_nxt;

  // memory ports
  logic          link_we;
  logic [BW-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
  logic          seen_we;
  logic [BW-1:0] seen_waddr, seen_wdata, seen_raddr, seen_rdata;

  logic          accept;
  logic [BW-1:0] n_force;
  logic [BW:0]   sweep_next;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign n_force = (num_blocks_r > efla_pkg::MAX_BLK) ? efla_pkg::MAX_BLK : num_blocks_r;
  assign sweep_next = {1'b0, cnt_r} + 1'b1;

  // link memory: next free block for every free block
  efla_ram #(.WIDTH(BW), .DEPTH(efla_pkg::MAX_BLOCKS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // seen marks for check: an entry is marked when it holds the current epoch
  efla_ram #(.WIDTH(BW), .DEPTH(efla_pkg::MAX_BLOCKS)) u_seen_ram (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (seen_wdata),
    .raddr (seen_raddr),
    .rdata (seen_rdata)
  );

  // APB: zero wait states, combinational read back
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      efla_pkg::REG_NUM_BLOCKS:  prdata = {{(efla_pkg::APB_W-BW){1'b0}}, num_blocks_r};
      efla_pkg::REG_BLOCK_BYTES: prdata = {{(efla_pkg::APB_W-efla_pkg::BYTES_W){1'b0}},
                                           block_bytes_r};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_blocks_r  <= efla_pkg::MAX_BLK;
      block_bytes_r <= efla_pkg::BYTES_W'(16);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == efla_pkg::REG_NUM_BLOCKS) begin
        num_blocks_r <= pwdata[BW-1:0];
      end else begin
        block_bytes_r <= pwdata[efla_pkg::BYTES_W-1:0];
      end
    end
  end

  // main controller
  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    cnt_nxt     = cnt_r;
    sweep_n_nxt = sweep_n_r;
    head_nxt    = head_r;
    total_nxt   = total_r;
    epoch_nxt   = epoch_r;
    idx_nxt     = idx_r;
    rem_nxt     = rem_r;
    blk_nxt     = blk_r;
    first_nxt   = first_r;

    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_gidx_nxt   = out_gidx_r;
    out_goff_nxt   = out_goff_r;
    out_isf_nxt    = out_isf_r;
    out_cor_nxt    = out_cor_r;
    out_cnt_nxt    = out_cnt_r;

    link_we    = 1'b0;
    link_waddr = cnt_r;
    link_wdata = '0;
    link_raddr = head_r;
    seen_we    = 1'b0;
    seen_waddr = idx_r;
    seen_wdata = epoch_r;
    seen_raddr = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // most results come out at the accept edge; fill in a plain word first
          out_status_nxt = efla_pkg::ST_OK;
          out_gidx_nxt   = '0;
          out_goff_nxt   = '0;
          out_isf_nxt    = 1'b0;
          out_cor_nxt    = 1'b0;
          out_cnt_nxt    = total_r;
          case (in_func)
            efla_pkg::F_ALLOC: begin
              if (total_r == '0) begin
                out_status_nxt = efla_pkg::ST_FULL;
                out_valid_nxt  = 1'b1;
              end else begin
                state_nxt = S_ALLOC;  // link of head is read this cycle
              end
            end
            efla_pkg::F_FREE: begin
              out_valid_nxt = 1'b1;
              if (in_block_index >= n_force) begin
                out_status_nxt = efla_pkg::ST_RANGE;
              end else if (total_r != '0 && head_r == in_block_index) begin
                out_status_nxt = efla_pkg::ST_DOUBLE;
              end else begin
                link_we    = 1'b1;
                link_waddr = in_block_index;
                link_wdata = head_r;
                head_nxt   = in_block_index;
                if (total_r != '1) begin
                  total_nxt   = total_r + 1'b1;
                  out_cnt_nxt = total_r + 1'b1;
                end
              end
            end
            efla_pkg::F_QUERY: begin
              blk_nxt = in_block_index;
              if (total_r == '0) begin
                out_valid_nxt = 1'b1;
              end else if (head_r == in_block_index) begin
                out_isf_nxt   = 1'b1;
                out_valid_nxt = 1'b1;
              end else if (total_r == BW'(1)) begin
                out_valid_nxt = 1'b1;
              end else begin
                rem_nxt   = total_r - 1'b1;
                state_nxt = S_QUERY;
              end
            end
            efla_pkg::F_CHECK: begin
              if (total_r > n_force) begin
                out_cor_nxt   = 1'b1;
                out_valid_nxt = 1'b1;
              end else if (total_r == '0) begin
                out_valid_nxt = 1'b1;
              end else if (head_r >= n_force) begin
                out_cor_nxt   = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                idx_nxt   = head_r;
                rem_nxt   = total_r - 1'b1;
                first_nxt = 1'b1;
                if (epoch_r == efla_pkg::EPOCH_TOP) begin
                  // epochs used up: clear the marks first
                  kind_nxt  = K_SEEN;
                  cnt_nxt   = '0;
                  state_nxt = S_SWEEP;
                end else begin
                  epoch_nxt = epoch_r + 1'b1;
                  state_nxt = S_CMARK;
                end
              end
            end
            efla_pkg::F_REINIT: begin
              kind_nxt    = K_REINIT;
              cnt_nxt     = '0;
              sweep_n_nxt = n_force;
              state_nxt   = S_SWEEP;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_ALLOC: begin
        head_nxt       = link_rdata;
        total_nxt      = total_r - 1'b1;
        out_gidx_nxt   = head_r;
        out_goff_nxt   = efla_pkg::OFFSET_W'(head_r) * efla_pkg::OFFSET_W'(block_bytes_r);
        out_cnt_nxt    = total_r - 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end

      S_QUERY: begin
        // link_rdata is the next block on the list
        if (link_rdata == blk_r) begin
          out_isf_nxt   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (rem_r == BW'(1)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          rem_nxt    = rem_r - 1'b1;
          link_raddr = link_rdata;
        end
      end

      S_CMARK: begin
        if (!first_r && seen_rdata == epoch_r) begin
          out_cor_nxt   = 1'b1;  // repeated link
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          seen_we = 1'b1;
          if (rem_r == '0) begin
            out_valid_nxt = 1'b1;  // last free block: its link is not followed
            state_nxt     = S_IDLE;
          end else begin
            link_raddr = idx_r;
            state_nxt  = S_CLINK;
          end
        end
      end

      S_CLINK: begin
        rem_nxt = rem_r - 1'b1;
        if (link_rdata >= n_force) begin
          out_cor_nxt   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt    = link_rdata;
          seen_raddr = link_rdata;
          first_nxt  = 1'b0;
          state_nxt  = S_CMARK;
        end
      end

      S_SWEEP: begin
        link_we    = (kind_r != K_SEEN);
        link_waddr = cnt_r;
        link_wdata = (sweep_next < {1'b0, sweep_n_r}) ? sweep_next[BW-1:0] : '0;
        seen_we    = 1'b1;
        seen_waddr = cnt_r;
        seen_wdata = '0;
        if (cnt_r == efla_pkg::LAST_BLK) begin
          epoch_nxt = '0;
          unique case (kind_r)
            K_SEEN: begin
              epoch_nxt = BW'(1);
              state_nxt = S_CMARK;
            end
            K_REINIT: begin
              head_nxt       = '0;
              total_nxt      = sweep_n_r;
              out_status_nxt = efla_pkg::ST_OK;
              out_gidx_nxt   = '0;
              out_goff_nxt   = '0;
              out_isf_nxt    = 1'b0;
              out_cor_nxt    = 1'b0;
              out_cnt_nxt    = sweep_n_r;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end
            default: begin
              head_nxt  = '0;
              total_nxt = sweep_n_r;
              state_nxt = S_IDLE;
            end
          endcase
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      kind_r      <= K_RESET;
      cnt_r       <= '0;
      sweep_n_r   <= efla_pkg::MAX_BLK;
      head_r      <= '0;
      total_r     <= efla_pkg::MAX_BLK;
      epoch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      cnt_r       <= cnt_nxt;
      sweep_n_r   <= sweep_n_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      epoch_r     <= epoch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walk payload and result word
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    rem_r        <= rem_nxt;
    blk_r        <= blk_nxt;
    first_r      <= first_nxt;
    out_status_r <= out_status_nxt;
    out_gidx_r   <= out_gidx_nxt;
    out_goff_r   <= out_goff_nxt;
    out_isf_r    <= out_isf_nxt;
    out_cor_r    <= out_cor_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_index  = out_gidx_r;
  assign out_granted_offset = out_goff_r;
  assign out_is_free        = out_isf_r;
  assign out_corrupt        = out_cor_r;
  assign out_free_count     = out_cnt_r;

  // reported free count always tracks the list state it came from
  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_free_count == total_r)
    else $error("free_count word differs from free total");

  // a free is answered from idle: its result word is registered straight from the accept and busy stays low
  a_free_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == efla_pkg::F_FREE) |=> (out_valid && !busy))
    else $error("free did not complete in one cycle");

  // pool full only when nothing is left
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == efla_pkg::ST_FULL) |-> out_free_count == '0)
    else $error("pool full reported with free blocks");

  // sweep stays inside the memories
  a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWEEP |-> cnt_r <= efla_pkg::LAST_BLK)
    else $error("sweep index past last entry");

endmodule

### rtl/efla_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module efla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
